// File: rtl/sdt_pkg.sv
// Shared types, constants and codes for the sorted date table with expiry.
package sdt_pkg;

  localparam int unsigned DateW             = 19;
  localparam int unsigned CountW            = 7;
  localparam int unsigned TableDepthDefault = 64;

  localparam logic [DateW-1:0] DateLow  = 19'd1;
  localparam logic [DateW-1:0] DateHigh = 19'd500000;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_STEP   = 2'd1,
    REQ_LOOKUP = 2'd2
  } sdt_req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DATES = 2'd1,
    ST_FULL      = 2'd2
  } sdt_status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEARCH,
    OP_SHIFT,
    OP_PLACE,
    OP_PRUNE
  } sdt_op_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DateW-1:0] ev_date;
    logic [DateW-1:0] er_date;
    logic [DateW-1:0] step_date;
  } sdt_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [CountW-1:0] entry_count;
    logic [DateW-1:0]  max_er_date;
    logic [CountW-1:0] removed_count;
  } sdt_rsp_t;

  typedef struct packed {
    logic [DateW-1:0] ev;
    logic [DateW-1:0] er;
  } sdt_entry_t;

  typedef struct packed {
    sdt_op_e op;
  } sdt_cmd_t;

  typedef struct packed {
    logic bad_dates;
    logic prune_needed;
    logic at_end;
    logic scan_end;
    logic hit;
    logic full;
    logic shift_last;
  } sdt_stat_t;

  function automatic logic dates_bad(logic [DateW-1:0] ev, logic [DateW-1:0] er);
    return (ev <= DateLow) || (ev >= DateHigh) || (er <= DateLow) || (er >= DateHigh) ||
           (ev < er);
  endfunction

endpackage

// File: rtl/sdt_ctrl.sv
// Controller state machine that sequences search, shift, place and prune passes.
module sdt_ctrl import sdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] req_type_i,
  input  sdt_stat_t  stat_i,
  output sdt_cmd_t   cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_PRUNE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic       done_q, done_d;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    done_d    = 1'b0;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          kind_d   = req_type_i;
          if (req_type_i == REQ_INSERT) begin
            if (stat_i.bad_dates) begin
              done_d = 1'b1;
            end else begin
              state_d = S_SEARCH;
            end
          end else if (req_type_i == REQ_STEP) begin
            if (stat_i.prune_needed) begin
              state_d = S_PRUNE;
            end else begin
              done_d = 1'b1;
            end
          end else if (req_type_i == REQ_LOOKUP) begin
            state_d = S_SEARCH;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        cmd_o.op = OP_SEARCH;
        if (stat_i.scan_end) begin
          if (kind_q == REQ_INSERT && !stat_i.hit && !stat_i.full) begin
            state_d = stat_i.at_end ? S_PLACE : S_SHIFT;
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        if (stat_i.shift_last) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.op = OP_PLACE;
        state_d  = S_IDLE;
        done_d   = 1'b1;
      end
      S_PRUNE: begin
        cmd_o.op = OP_PRUNE;
        if (stat_i.at_end) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  // A result is only announced once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a pass is still running");

  // The shift pass can only follow a search that missed.
  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> ($past(state_q) == S_SEARCH || $past(state_q) == S_SHIFT))
    else $error("shift pass entered without a search");

  // An accepted beat always leaves the idle state or raises the strobe.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_q))
    else $error("accepted beat was dropped");

endmodule

// File: rtl/sdt_dpath.sv
// Datapath: entry memory, pointers, running maximum and result registers.
module sdt_dpath import sdt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sdt_req_t  req_i,
  input  sdt_cmd_t  cmd_i,
  output sdt_stat_t stat_o,
  output sdt_rsp_t  rsp_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TableDepth);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  sdt_entry_t mem_q [TableDepth];
  sdt_entry_t rd_data_q;

  sdt_req_t         req_q, req_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DateW-1:0] max_q, max_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  wptr_q, wptr_d;
  logic [DateW-1:0] mmax_q, mmax_d;
  logic [1:0]       status_q, status_d;
  logic             found_q, found_d;
  logic [CntW-1:0]  removed_q, removed_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  sdt_entry_t       mem_wd;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  shift_dst;

  logic at_end, scan_end, hit, full, bad_in;

  assign at_end    = (ptr_q >= cnt_q);
  assign scan_end  = at_end || (rd_data_q.ev >= req_q.ev_date);
  assign hit       = !at_end && (rd_data_q.ev == req_q.ev_date);
  assign full      = (cnt_q >= DepthC);
  assign bad_in    = dates_bad(req_i.ev_date, req_i.er_date);
  assign shift_dst = ptr_q + OneC;

  assign stat_o.bad_dates    = bad_in;
  assign stat_o.prune_needed = (cnt_q != '0) && (req_i.step_date < max_q);
  assign stat_o.at_end       = at_end;
  assign stat_o.scan_end     = scan_end;
  assign stat_o.hit          = hit;
  assign stat_o.full         = full;
  assign stat_o.shift_last   = (ptr_q == wptr_q);

  always_comb begin
    req_d     = req_q;
    cnt_d     = cnt_q;
    max_d     = max_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    mmax_d    = mmax_q;
    status_d  = status_q;
    found_d   = found_q;
    removed_d = removed_q;
    mem_we    = 1'b0;
    mem_wa    = ptr_q[AddrW-1:0];
    mem_wd    = rd_data_q;
    case (cmd_i.op)
      OP_LOAD: begin
        req_d     = req_i;
        ptr_d     = '0;
        wptr_d    = '0;
        mmax_d    = '0;
        found_d   = 1'b0;
        removed_d = '0;
        status_d  = (req_i.req_type == REQ_INSERT && bad_in) ? ST_BAD_DATES : ST_OK;
      end
      OP_SEARCH: begin
        if (!scan_end) begin
          ptr_d = ptr_q + OneC;
        end else begin
          // Remember the insert position and prime the read for a shift pass.
          wptr_d = ptr_q;
          ptr_d  = cnt_q - OneC;
          if (req_q.req_type == REQ_LOOKUP) begin
            found_d = hit;
          end else if (req_q.req_type == REQ_INSERT) begin
            if (hit) begin
              found_d   = 1'b1;
              mem_we    = 1'b1;
              mem_wd.ev = req_q.ev_date;
              mem_wd.er = (req_q.er_date < rd_data_q.er) ? req_q.er_date : rd_data_q.er;
              if (req_q.er_date > max_q) begin
                max_d = req_q.er_date;
              end
            end else if (full) begin
              status_d = ST_FULL;
            end
          end
        end
      end
      OP_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = shift_dst[AddrW-1:0];
        ptr_d  = ptr_q - OneC;
      end
      OP_PLACE: begin
        mem_we    = 1'b1;
        mem_wa    = wptr_q[AddrW-1:0];
        mem_wd.ev = req_q.ev_date;
        mem_wd.er = req_q.er_date;
        cnt_d     = cnt_q + OneC;
        if (req_q.er_date > max_q) begin
          max_d = req_q.er_date;
        end
      end
      OP_PRUNE: begin
        if (!at_end) begin
          ptr_d = ptr_q + OneC;
          if (req_q.step_date >= rd_data_q.er) begin
            mem_we = 1'b1;
            mem_wa = wptr_q[AddrW-1:0];
            wptr_d = wptr_q + OneC;
            if (rd_data_q.er > mmax_q) begin
              mmax_d = rd_data_q.er;
            end
          end else begin
            removed_d = removed_q + OneC;
          end
        end else begin
          cnt_d = wptr_q;
          max_d = mmax_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Pointers may run one past either end of the table; those reads are ignored.
  always_comb begin
    if (ptr_d < DepthC) begin
      rd_addr = ptr_d[AddrW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q     <= '0;
      cnt_q     <= '0;
      max_q     <= '0;
      ptr_q     <= '0;
      wptr_q    <= '0;
      mmax_q    <= '0;
      status_q  <= ST_OK;
      found_q   <= 1'b0;
      removed_q <= '0;
    end else begin
      req_q     <= req_d;
      cnt_q     <= cnt_d;
      max_q     <= max_d;
      ptr_q     <= ptr_d;
      wptr_q    <= wptr_d;
      mmax_q    <= mmax_d;
      status_q  <= status_d;
      found_q   <= found_d;
      removed_q <= removed_d;
    end
  end

  assign rsp_o.status        = status_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.entry_count   = CountW'(cnt_q);
  assign rsp_o.max_er_date   = max_q;
  assign rsp_o.removed_count = CountW'(removed_q);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count beyond table depth");

  // Compaction never writes ahead of the entry it is reading.
  a_prune_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PRUNE) |-> (wptr_q <= ptr_q))
    else $error("prune write pointer overtook read pointer");

  // A place always grows the table by exactly one entry.
  a_place_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PLACE) |=> (cnt_q == $past(cnt_q) + OneC))
    else $error("place did not add one entry");

endmodule

// File: rtl/sorted_date_table_with_expiry.sv
// Top level of the sorted date table with expiry: controller plus datapath.
//
//   channel   signals                      handshake
//   -------   --------------------------   ------------------------------------
//   request   start, busy, req_i           beat taken when start high, busy low
//   result    done_o, rsp_o                one beat per request, done_o for one
//                                          cycle, cannot be held off
//
// Passes: a lookup scans the entries from the first one up to the position
// that it stops at; an insert of a new date searches, moves the later entries
// up one place and writes the new entry; a time step that prunes compacts the
// whole table. A refused insert, a step with nothing to prune and an unused
// request code answer in the next cycle. The length of a pass is set by the
// single read port and single write port of the entry memory, which every
// pass walks one entry per cycle. Reset clears the entry count and the running
// maximum; the memory itself is not cleared, since only entries below the count
// are ever read. The result side cannot stall, and a new beat may be taken in
// the same cycle that the previous result is on the ports.
module sorted_date_table_with_expiry import sdt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sdt_req_t req_i,
  output logic     done_o,
  output sdt_rsp_t rsp_o
);

  sdt_cmd_t  cmd;
  sdt_stat_t stat;

  // The controller decides which pass runs next from the datapath status.
  sdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o)
  );

  // The datapath holds the sorted entries and the result registers, which
  // hold from the end of one request until the next one is accepted.
  sdt_dpath #(
    .TableDepth (TableDepth)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

// File: dv/sorted_date_table_with_expiry_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted date table with expiry.
module sorted_date_table_with_expiry_tb;
  import sdt_pkg::*;

  localparam int unsigned TableDepth  = TableDepthDefault;
  localparam int          RandomItems = 850;
  // The slowest pass walks the whole table once, so a few table lengths of
  // quiet cycles are enough to catch a stray result after the last one.
  localparam int          DrainCycles = 4 * TableDepth;
  // The request code that the block leaves unused.
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [DateW-1:0] DateAllOnes = '1;

  // Kinds of random beat and the mixes that weight them.
  typedef enum {
    KIND_INSERT,
    KIND_MERGE,
    KIND_LOOKUP,
    KIND_STEP,
    KIND_NOISE
  } stim_kind_e;

  typedef enum {
    MIX_FILL,
    MIX_BALANCED,
    MIX_PRUNE
  } mix_e;

  // One row of the directed table. Where typed is set, the expected result
  // is the one written in the row; otherwise the table model supplies it.
  typedef struct {
    logic [1:0] req;
    int         ev;
    int         er;
    int         now;
    bit         typed;
    logic [1:0] st;
    bit         hit;
    int         cnt;
    int         mx;
    int         rm;
  } dir_row_t;

  localparam int NumDirected = 23;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  sdt_req_t req_i;
  logic     done_o;
  sdt_rsp_t rsp_o;

  // Table model: the entries sorted by evaluation date, the number of valid
  // entries and the running maximum of the earliest-use dates.
  logic [DateW-1:0] tbl_ev [TableDepth];
  logic [DateW-1:0] tbl_er [TableDepth];
  int unsigned      tbl_count;
  logic [DateW-1:0] tbl_max;

  // Results still owed by the block, oldest first.
  sdt_rsp_t    expected_rsps [$];
  sdt_rsp_t    oldest;
  int unsigned mismatches;
  // Beats left in the current burst before the sender goes quiet.
  int unsigned burst_left;

  dir_row_t dir_rows [NumDirected];

  sorted_date_table_with_expiry #(
    .TableDepth(TableDepth)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A generous bound: every beat at the slowest table walk plus the longest
  // sender gap comes to under a fifth of this.
  initial begin
    #5_000_000;
    $display("sorted_date_table_with_expiry test failed");
    $finish;
  end

  // Both dates must lie strictly inside the legal window, and the earliest-use
  // date may not lie after the entry's own evaluation date.
  function automatic bit dates_invalid(input logic [DateW-1:0] ev,
                                       input logic [DateW-1:0] er);
    bit ev_ok;
    bit er_ok;
    ev_ok = (ev > DateLow) && (ev < DateHigh);
    er_ok = (er > DateLow) && (er < DateHigh);
    return !(ev_ok && er_ok && (er <= ev));
  endfunction

  // Position of the first entry whose evaluation date is not below the key.
  function automatic int unsigned first_at_or_after(input logic [DateW-1:0] key);
    int unsigned pos;
    pos = 0;
    while (pos < tbl_count && tbl_ev[pos] < key) pos++;
    return pos;
  endfunction

  // Applies one accepted beat to the table model and returns the result the
  // block should give for it.
  function automatic sdt_rsp_t predict_table(input sdt_req_t item);
    sdt_rsp_t         rsp;
    int unsigned      pos;
    int unsigned      kept;
    int unsigned      pruned;
    logic [DateW-1:0] top;
    rsp = '0;
    case (item.req_type)
      REQ_INSERT: begin
        if (dates_invalid(item.ev_date, item.er_date)) begin
          rsp.status = ST_BAD_DATES;
        end else begin
          pos = first_at_or_after(item.ev_date);
          if (pos < tbl_count && tbl_ev[pos] == item.ev_date) begin
            // A merge keeps the smaller usage date but still feeds the
            // running maximum with the new one.
            rsp.found = 1'b1;
            if (item.er_date < tbl_er[pos]) tbl_er[pos] = item.er_date;
            if (item.er_date > tbl_max) tbl_max = item.er_date;
          end else if (tbl_count >= TableDepth) begin
            rsp.status = ST_FULL;
          end else begin
            for (int unsigned i = tbl_count; i > pos; i--) begin
              tbl_ev[i] = tbl_ev[i-1];
              tbl_er[i] = tbl_er[i-1];
            end
            tbl_ev[pos] = item.ev_date;
            tbl_er[pos] = item.er_date;
            tbl_count++;
            if (item.er_date > tbl_max) tbl_max = item.er_date;
          end
        end
      end
      REQ_STEP: begin
        // Nothing happens on an empty table or when no entry can expire.
        if (tbl_count != 0 && item.step_date < tbl_max) begin
          kept   = 0;
          pruned = 0;
          top    = '0;
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (item.step_date < tbl_er[i]) begin
              pruned++;
            end else begin
              tbl_ev[kept] = tbl_ev[i];
              tbl_er[kept] = tbl_er[i];
              if (tbl_er[i] > top) top = tbl_er[i];
              kept++;
            end
          end
          tbl_count = kept;
          tbl_max   = top;
          rsp.removed_count = CountW'(pruned);
        end
      end
      REQ_LOOKUP: begin
        pos = first_at_or_after(item.ev_date);
        rsp.found = (pos < tbl_count) && (tbl_ev[pos] == item.ev_date);
      end
      default: ;
    endcase
    rsp.entry_count = CountW'(tbl_count);
    rsp.max_er_date = tbl_max;
    return rsp;
  endfunction

  function automatic stim_kind_e pick_kind(input mix_e mix);
    int unsigned roll;
    int unsigned ins;
    int unsigned mrg;
    int unsigned look;
    int unsigned stp;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        ins = 70; mrg = 12; look = 8; stp = 2;
      end
      MIX_BALANCED: begin
        ins = 40; mrg = 15; look = 20; stp = 15;
      end
      default: begin
        ins = 30; mrg = 10; look = 15; stp = 40;
      end
    endcase
    if (roll < ins) return KIND_INSERT;
    if (roll < ins + mrg) return KIND_MERGE;
    if (roll < ins + mrg + look) return KIND_LOOKUP;
    if (roll < ins + mrg + look + stp) return KIND_STEP;
    return KIND_NOISE;
  endfunction

  // Builds one random beat. Fields that the request does not use carry
  // random junk, which the block must ignore.
  function automatic sdt_req_t make_item(input stim_kind_e kind);
    sdt_req_t    item;
    int unsigned ev;
    int unsigned sel;
    item.req_type  = 2'($urandom);
    item.ev_date   = DateW'($urandom);
    item.er_date   = DateW'($urandom);
    item.step_date = DateW'($urandom);
    if (kind == KIND_MERGE && tbl_count == 0) kind = KIND_INSERT;
    case (kind)
      KIND_INSERT: begin
        item.req_type = REQ_INSERT;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          // Widest legal spread between the two dates.
          item.ev_date = DateHigh - 1;
          item.er_date = DateLow + 1;
        end else begin
          ev = $urandom_range(DateLow + 1, DateHigh - 1);
          item.ev_date = DateW'(ev);
          item.er_date = (sel < 3) ? DateW'(ev) : DateW'($urandom_range(DateLow + 1, ev));
        end
      end
      KIND_MERGE: begin
        item.req_type = REQ_INSERT;
        ev = 32'(tbl_ev[$urandom_range(0, tbl_count - 1)]);
        item.ev_date = DateW'(ev);
        item.er_date = DateW'($urandom_range(DateLow + 1, ev));
      end
      KIND_LOOKUP: begin
        item.req_type = REQ_LOOKUP;
        if (tbl_count != 0 && $urandom_range(0, 4) < 3) begin
          item.ev_date = tbl_ev[$urandom_range(0, tbl_count - 1)];
        end
      end
      KIND_STEP: begin
        item.req_type = REQ_STEP;
        sel = $urandom_range(0, 9);
        case (sel)
          0:       item.step_date = DateW'($urandom_range(0, 1));  // expires everything
          1:       item.step_date = tbl_max;                       // just too late to prune
          2:       ;                                               // anywhere at all
          default: item.step_date = DateW'($urandom_range(0, tbl_max));
        endcase
      end
      default: ;
    endcase
    return item;
  endfunction

  // Offers one beat and holds it until the block takes it. The model is
  // advanced at the accepting edge, so its state always matches the block's
  // view when the next beat is built. Gaps between bursts drop start for a
  // random number of cycles so that new beats land on every stage of a pass.
  task automatic send_beat(input sdt_req_t item, input bit typed,
                           input sdt_rsp_t typed_rsp);
    sdt_rsp_t    want;
    int unsigned gap;
    start <= 1'b1;
    req_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = predict_table(item);
    if (typed) want = typed_rsp;
    expected_rsps = {expected_rsps, want};
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Each result is on the ports for one cycle only, so it is sampled at the
  // edge that ends that cycle and compared with the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, got %h",
                 $time, rsp_o);
        mismatches++;
      end else begin
        oldest = expected_rsps.pop_front();
        check_field("status", 32'(oldest.status), 32'(rsp_o.status));
        check_field("found", 32'(oldest.found), 32'(rsp_o.found));
        check_field("entry_count", 32'(oldest.entry_count), 32'(rsp_o.entry_count));
        check_field("max_er_date", 32'(oldest.max_er_date), 32'(rsp_o.max_er_date));
        check_field("removed_count", 32'(oldest.removed_count),
                    32'(rsp_o.removed_count));
      end
    end
  end

  initial begin
    sdt_req_t   item;
    sdt_rsp_t   want;
    mix_e       mix;
    stim_kind_e kind;
    int         seg_left;
    int         taken;
    int unsigned pick;

    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    tbl_count  = 0;
    tbl_max    = '0;
    mismatches = 0;
    burst_left = $urandom_range(0, 12);

    // Directed rows: the empty table, every refused date pair, merges that
    // lower the stored date and that raise only the maximum, a step that
    // cannot prune, a step that prunes nothing yet lowers the maximum, and a
    // step that empties the table.
    dir_rows = '{
      '{REQ_LOOKUP, 2, 0, 0, 1, ST_OK, 0, 0, 0, 0},
      '{REQ_STEP, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0},
      '{REQ_UNUSED, DateAllOnes, DateAllOnes, DateAllOnes, 1, ST_OK, 0, 0, 0, 0},
      '{REQ_INSERT, 1, 1, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, 500000, 2, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, 499999, 500000, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, 10, 11, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, 3, 1, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, DateAllOnes, DateAllOnes, 0, 1, ST_BAD_DATES, 0, 0, 0, 0},
      '{REQ_INSERT, 2, 2, 0, 1, ST_OK, 0, 1, 2, 0},
      '{REQ_INSERT, 499999, 499999, 0, 1, ST_OK, 0, 2, 499999, 0},
      '{REQ_INSERT, 1000, 900, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_INSERT, 1000, 950, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_INSERT, 1000, 800, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_LOOKUP, 1000, 0, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_LOOKUP, 999, 0, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_STEP, 0, 0, 499999, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_STEP, 0, 0, 1000, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_INSERT, 1000, 1000, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_STEP, 0, 0, 900, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_INSERT, 500, 3, 0, 0, ST_OK, 0, 0, 0, 0},
      '{REQ_STEP, 0, 0, 1, 1, ST_OK, 0, 0, 0, 3},
      '{REQ_LOOKUP, 2, 0, 0, 1, ST_OK, 0, 0, 0, 0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      item.req_type      = dir_rows[i].req;
      item.ev_date       = DateW'(dir_rows[i].ev);
      item.er_date       = DateW'(dir_rows[i].er);
      item.step_date     = DateW'(dir_rows[i].now);
      want.status        = dir_rows[i].st;
      want.found         = dir_rows[i].hit;
      want.entry_count   = CountW'(dir_rows[i].cnt);
      want.max_er_date   = DateW'(dir_rows[i].mx);
      want.removed_count = CountW'(dir_rows[i].rm);
      send_beat(item, dir_rows[i].typed, want);
    end

    // Random part in segments. Fill segments drive the table into its full
    // state, where new dates are refused and merges still go through; the
    // other mixes prune it down again.
    taken    = 0;
    seg_left = 0;
    mix      = MIX_FILL;
    while (taken < RandomItems) begin
      if (seg_left <= 0) begin
        pick     = $urandom_range(0, 3);
        mix      = (pick < 2) ? MIX_FILL : ((pick == 2) ? MIX_BALANCED : MIX_PRUNE);
        seg_left = $urandom_range(40, 120);
      end
      kind = pick_kind(mix);
      send_beat(make_item(kind), 1'b0, '0);
      taken++;
      seg_left--;
    end

    start <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("sorted_date_table_with_expiry test passed");
    end else begin
      $display("sorted_date_table_with_expiry test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sdt_pkg.sv
rtl/sdt_ctrl.sv
rtl/sdt_dpath.sv
rtl/sorted_date_table_with_expiry.sv
dv/sorted_date_table_with_expiry_tb.sv
